// ----- sv/hsfd_pkg.sv -----
// Shared types, codes and the CRC-8 step for the humidity sensor frame decoder.
// Used by hsfd_convert and the top level; depends on nothing else.
package hsfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Byte position that closes a frame.
	localparam logic [2:0] LAST_IDX = 3'd5;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_CRC    = 2'd1,
		ST_SENSOR = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	// Sensor family codes; the unused code decodes like the one-byte-command family.
	localparam logic [1:0] FAM_ONE_BYTE = 2'd0;
	localparam logic [1:0] FAM_TWO_BYTE = 2'd1;
	localparam logic [1:0] FAM_PACKED   = 2'd2;

	// A complete frame, as handed from the byte collector to the converter.
	typedef struct packed {
		logic [1:0] family;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b4;
		logic [7:0] b5;
		logic       word0_ok;
		logic       word1_ok;
	} frame_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- sv/hsfd_convert.sv -----
// Converts one complete frame to temperature, humidity and status.
// Purely combinational; depends on hsfd_pkg for the frame struct and codes.
module hsfd_convert (
	input  hsfd_pkg::frame_t  frame,
	output logic signed [14:0] temp_centi,
	output logic [13:0]        humidity_centi,
	output hsfd_pkg::status_t  status
);
	import hsfd_pkg::*;

	// Exact floor(x / 65535) for the products seen here (quotient well below 2^16).
	function automatic logic [15:0] div65535(input logic [31:0] x);
		logic [32:0] s;
		s = {1'b0, x} + 33'(x[31:16]) + 33'd1;
		return s[31:16];
	endfunction

	logic [15:0] rt, rh;
	logic [19:0] raw_h, raw_t;

	logic [30:0] f0_tprod, f0_hprod;
	logic [15:0] f0_tq, f0_hq;
	logic signed [15:0] f0_temp;
	logic [13:0] f0_hum;

	logic [28:0] f1_tprod;
	logic [25:0] f1_hprod;
	logic signed [15:0] f1_temp;

	logic [34:0] f2_tprod;
	logic [33:0] f2_hprod;
	logic signed [15:0] f2_temp;
	logic        f2_sensor_ok, f2_in_range;

	assign rt    = {frame.b0, frame.b1};
	assign rh    = {frame.b3, frame.b4};
	assign raw_h = {frame.b1, frame.b2, frame.b3[7:4]};
	assign raw_t = {frame.b3[3:0], frame.b4, frame.b5};

	// One-byte-command family: linear scaling over full scale 65535.
	assign f0_tprod = 31'(rt) * 31'd17500;
	assign f0_hprod = 31'(rh) * 31'd12500;
	assign f0_tq    = div65535({1'b0, f0_tprod});
	assign f0_hq    = div65535({1'b0, f0_hprod});
	assign f0_temp  = $signed(f0_tq) - 16'sd4500;

	always_comb begin
		if (f0_hq < 16'd600) begin
			f0_hum = '0;
		end else if (f0_hq > 16'd10600) begin
			f0_hum = 14'd10000;
		end else begin
			f0_hum = 14'(f0_hq - 16'd600);
		end
	end

	// Two-byte-command family: fixed shift formulas, no range check.
	assign f1_tprod = 29'(rt) * 29'd4375;
	assign f1_hprod = 26'(rh) * 26'd625;
	assign f1_temp  = $signed({1'b0, f1_tprod[28:14]}) - 16'sd4500;

	// Packed family: 20-bit fields over 2^20.
	assign f2_tprod     = 35'(raw_t) * 35'd20000;
	assign f2_hprod     = 34'(raw_h) * 34'd10000;
	assign f2_temp      = $signed({1'b0, f2_tprod[34:20]}) - 16'sd5000;
	assign f2_sensor_ok = (frame.b0 & 8'h98) == 8'h18;
	// Valid window is -40..90 C, i.e. 52429 <= raw_t <= 734003.
	assign f2_in_range  = (raw_t > 20'd52428) && (raw_t < 20'd734004);

	always_comb begin
		temp_centi     = '0;
		humidity_centi = '0;
		status         = ST_OK;
		case (frame.family)
			FAM_PACKED: begin
				if (!f2_sensor_ok) begin
					status = ST_SENSOR;
				end else if (!f2_in_range) begin
					status = ST_RANGE;
				end else begin
					temp_centi     = f2_temp[14:0];
					humidity_centi = f2_hprod[33:20];
				end
			end
			FAM_TWO_BYTE: begin
				if (!frame.word0_ok || !frame.word1_ok) begin
					status = ST_CRC;
				end else begin
					temp_centi     = f1_temp[14:0];
					humidity_centi = f1_hprod[25:12];
				end
			end
			default: begin
				// The temperature window can never be left with a 16-bit raw value.
				if (!frame.word0_ok || !frame.word1_ok) begin
					status = ST_CRC;
				end else begin
					temp_centi     = f0_temp[14:0];
					humidity_centi = f0_hum;
				end
			end
		endcase
	end

endmodule

// ----- sv/humidity_sensor_frame_decoder_top.sv -----
// Top level of the humidity sensor frame decoder: byte collection, CRC, output register.
// Depends on hsfd_pkg and hsfd_convert.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | rx_byte[7:0], frame_start
//  out      | out_valid / out_stall| temp_centi[14:0], humidity_centi[13:0], status[1:0]
//  config   | cfg_wr_en            | cfg_wr_data[1:0] (sensor family)
//
// One byte is accepted per cycle while in_stall is low. The sixth byte of a frame goes
// to a frame register, and its result moves on to the output register once that register
// can take it. in_stall rises only while both the frame register and the output
// register are full and out_stall is high. Reset clears the byte count, the CRC, valid
// flags and the family; held bytes are not reset.
module humidity_sensor_frame_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [14:0]  temp_centi,
	output logic [13:0]         humidity_centi,
	output logic [1:0]          status
);
	import hsfd_pkg::*;

	logic [1:0] family_q;
	logic [2:0] cnt_q;
	logic [7:0] crc_q;
	logic       word0_ok_q;
	logic [7:0] held_q [5];

	logic       in_acc;
	logic [2:0] idx;
	logic       out_ready;

	logic       valid_s1;
	frame_t     frame_s1;

	logic              out_valid_q;
	logic signed [14:0] temp_q;
	logic [13:0]       hum_q;
	status_t           status_q;

	logic signed [14:0] conv_temp;
	logic [13:0]       conv_hum;
	status_t           conv_status;

	assign out_ready = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !out_ready;
	assign in_acc    = in_valid && !in_stall;

	always_comb begin
		idx = frame_start ? 3'd0 : cnt_q;
		if (idx > LAST_IDX) begin
			idx = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			family_q <= FAM_ONE_BYTE;
		end else if (cfg_wr_en) begin
			family_q <= cfg_wr_data;
		end
	end

	// Byte collector. The CRC register restarts at the first byte of each word and the
	// first word's check is kept as a flag once its CRC byte arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			crc_q      <= CRC_INIT;
			word0_ok_q <= 1'b0;
		end else if (in_acc) begin
			case (idx)
				3'd0, 3'd3: crc_q <= crc8_step(CRC_INIT, rx_byte);
				3'd1, 3'd4: crc_q <= crc8_step(crc_q, rx_byte);
				3'd2:       word0_ok_q <= (crc_q == rx_byte);
				default:    ;
			endcase
			cnt_q <= (idx == LAST_IDX) ? 3'd0 : idx + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && idx < LAST_IDX) begin
			held_q[idx] <= rx_byte;
		end
	end

	// Frame register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc && idx == LAST_IDX) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && idx == LAST_IDX) begin
			frame_s1.family   <= family_q;
			frame_s1.b0       <= held_q[0];
			frame_s1.b1       <= held_q[1];
			frame_s1.b2       <= held_q[2];
			frame_s1.b3       <= held_q[3];
			frame_s1.b4       <= held_q[4];
			frame_s1.b5       <= rx_byte;
			frame_s1.word0_ok <= word0_ok_q;
			frame_s1.word1_ok <= (crc_q == rx_byte);
		end
	end

	hsfd_convert u_convert (
		.frame          (frame_s1),
		.temp_centi     (conv_temp),
		.humidity_centi (conv_hum),
		.status         (conv_status)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1) begin
			temp_q   <= conv_temp;
			hum_q    <= conv_hum;
			status_q <= conv_status;
		end
	end

	assign out_valid      = out_valid_q;
	assign temp_centi     = temp_q;
	assign humidity_centi = hum_q;
	assign status         = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST_IDX)
		else $error("byte count beyond the last frame position");

	a_last_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && idx == LAST_IDX |=> valid_s1)
		else $error("closing byte did not load the frame register");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> temp_q == 15'sd0 && hum_q == 14'd0)
		else $error("failed frame carries nonzero readings");

	a_hum_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> hum_q <= 14'd10000)
		else $error("humidity above full scale");

endmodule

// ----- test/humidity_sensor_frame_decoder_top_tb.sv -----
// Self-checking testbench for humidity_sensor_frame_decoder_top: it sends byte frames for
// every sensor family and checks each decoded reading against its own predictor.
// Depends on hsfd_pkg and the decoder RTL.
module humidity_sensor_frame_decoder_top_tb;
	import hsfd_pkg::*;

	localparam logic [7:0] WORD_CRC_POLY = 8'h31;
	localparam logic [7:0] WORD_CRC_SEED = 8'hFF;
	localparam logic [7:0] SENSOR_MASK   = 8'h98;
	localparam logic [7:0] SENSOR_READY  = 8'h18;
	// The spare family code decodes like the one-byte-command family.
	localparam logic [1:0] FAM_SPARE     = 2'd3;
	localparam int         HOLD_CYCLES   = 300;

	typedef struct {
		logic signed [14:0] temp;
		logic [13:0]        hum;
		status_t            st;
	} reading_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [1:0]         cfg_wr_data = 2'd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               frame_start = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [14:0] temp_centi;
	logic [13:0]        humidity_centi;
	logic [1:0]         status;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent = 0;
	int hold_requests = 0;

	function automatic logic [7:0] crc8_serial(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ data[i];
			c = {c[6:0], 1'b0} ^ (fb ? WORD_CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	class reading_scoreboard;
		logic [1:0] family;
		int         bytes_held;
		logic [7:0] frame_bytes [5];
		logic [7:0] word1_crc;
		reading_t   pending_readings [$];
		int         mismatches;

		function new();
			family = FAM_ONE_BYTE;
			bytes_held = 0;
			word1_crc = WORD_CRC_SEED;
			mismatches = 0;
			foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
		endfunction

		function reading_t decode_frame(logic [7:0] last);
			reading_t r;
			logic [19:0] raw_h, raw_t;
			longint h_l, t_l, tn, val;
			r.temp = '0;
			r.hum = '0;
			r.st = ST_OK;
			if (family == FAM_PACKED) begin
				raw_h = {frame_bytes[1], frame_bytes[2], frame_bytes[3][7:4]};
				raw_t = {frame_bytes[3][3:0], frame_bytes[4], last};
				h_l = raw_h;
				t_l = raw_t;
				tn = t_l * 200;
				if ((frame_bytes[0] & SENSOR_MASK) != SENSOR_READY) begin
					r.st = ST_SENSOR;
				end else if (tn < (longint'(10) << 20) || tn > (longint'(140) << 20)) begin
					r.st = ST_RANGE;
				end else begin
					r.temp = 15'(((t_l * 20000) >> 20) - 5000);
					r.hum = 14'((h_l * 10000) >> 20);
				end
			end else begin
				t_l = {frame_bytes[0], frame_bytes[1]};
				h_l = {frame_bytes[3], frame_bytes[4]};
				if (crc8_serial(crc8_serial(WORD_CRC_SEED, frame_bytes[0]), frame_bytes[1])
						!= frame_bytes[2] || word1_crc != last) begin
					r.st = ST_CRC;
				end else if (family == FAM_TWO_BYTE) begin
					r.temp = 15'(((4375 * t_l) >> 14) - 4500);
					r.hum = 14'((625 * h_l) >> 12);
				end else begin
					// A 16-bit raw temperature can never leave the accepted range here.
					r.temp = 15'((t_l * 17500) / 65535 - 4500);
					val = (h_l * 12500) / 65535 - 600;
					if (val < 0) val = 0;
					if (val > 10000) val = 10000;
					r.hum = 14'(val);
				end
			end
			return r;
		endfunction

		function void note_byte(logic [7:0] b, logic fs);
			int slot;
			slot = fs ? 0 : bytes_held;
			if (slot > 5) slot = 0;
			if (slot < 5) begin
				frame_bytes[slot] = b;
				if (slot == 3)
					word1_crc = crc8_serial(WORD_CRC_SEED, b);
				else if (slot == 4)
					word1_crc = crc8_serial(word1_crc, b);
				bytes_held = slot + 1;
			end else begin
				bytes_held = 0;
				pending_readings.push_back(decode_frame(b));
			end
		endfunction

		function void check_reading(logic signed [14:0] t, logic [13:0] h, logic [1:0] s);
			reading_t e;
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected reading temp=%0d hum=%0d status=%0d", $time, t, h, s);
				mismatches++;
				return;
			end
			e = pending_readings.pop_front();
			if (t !== e.temp) begin
				$display("%0t: temp_centi expected %0d got %0d", $time, e.temp, t);
				mismatches++;
			end
			if (h !== e.hum) begin
				$display("%0t: humidity_centi expected %0d got %0d", $time, e.hum, h);
				mismatches++;
			end
			if (s !== e.st) begin
				$display("%0t: status expected %0d got %0d", $time, e.st, s);
				mismatches++;
			end
		endfunction
	endclass

	reading_scoreboard sb = new();

	humidity_sensor_frame_decoder_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.frame_start    (frame_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.temp_centi     (temp_centi),
		.humidity_centi (humidity_centi),
		.status         (status)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver: random stalls, plus a long hold-off whenever the sender asks for one.
	int hold_left = 0;
	int holds_seen = 0;
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (holds_seen != hold_requests) begin
			holds_seen = hold_requests;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Handshake signals settle after the rising edge, so both sides look at the falling edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_reading(temp_centi, humidity_centi, status);
	end

	task automatic send_byte(input logic [7:0] b, input logic fs);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= fs;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		sb.note_byte(b, fs);
		items_sent++;
		@(posedge clk);
	endtask

	task automatic send_word_frame(input logic [15:0] w0, input logic [15:0] w1,
			input logic bad0, input logic bad1, input logic fs);
		logic [7:0] c0, c1;
		c0 = crc8_serial(crc8_serial(WORD_CRC_SEED, w0[15:8]), w0[7:0]);
		c1 = crc8_serial(crc8_serial(WORD_CRC_SEED, w1[15:8]), w1[7:0]);
		if (bad0) c0 ^= 8'($urandom_range(1, 255));
		if (bad1) c1 ^= 8'($urandom_range(1, 255));
		send_byte(w0[15:8], fs);
		send_byte(w0[7:0], 1'b0);
		send_byte(c0, 1'b0);
		send_byte(w1[15:8], 1'b0);
		send_byte(w1[7:0], 1'b0);
		send_byte(c1, 1'b0);
	endtask

	task automatic send_packed_frame(input logic [7:0] st, input logic [19:0] raw_h,
			input logic [19:0] raw_t, input logic fs);
		send_byte(st, fs);
		send_byte(raw_h[19:12], 1'b0);
		send_byte(raw_h[11:4], 1'b0);
		send_byte({raw_h[3:0], raw_t[19:16]}, 1'b0);
		send_byte(raw_t[15:8], 1'b0);
		send_byte(raw_t[7:0], 1'b0);
	endtask

	task automatic send_random_frame();
		logic [15:0] w0, w1;
		logic [19:0] raw_h, raw_t;
		logic [7:0]  st;
		logic        fs;
		fs = ($urandom_range(0, 3) != 0);
		if (sb.family == FAM_PACKED) begin
			st = 8'($urandom);
			if ($urandom_range(0, 4) != 0) st = (st & ~SENSOR_MASK) | SENSOR_READY;
			raw_h = ($urandom_range(0, 7) == 0) ? 20'hFFFFF : 20'($urandom);
			case ($urandom_range(0, 5))
				// Just around the lower and upper temperature limits.
				0: raw_t = 20'd52427 + 20'($urandom_range(0, 2));
				1: raw_t = 20'd734002 + 20'($urandom_range(0, 2));
				2: raw_t = ($urandom_range(0, 1) != 0) ? 20'hFFFFF : 20'h00000;
				default: raw_t = 20'($urandom);
			endcase
			send_packed_frame(st, raw_h, raw_t, fs);
		end else begin
			w0 = ($urandom_range(0, 4) == 0) ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
			w1 = ($urandom_range(0, 4) == 0) ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
			send_word_frame(w0, w1, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, fs);
		end
	endtask

	task automatic run_random(input int budget, input logic with_hold);
		int start;
		int pick;
		int n;
		logic hold_asked;
		start = items_sent;
		hold_asked = 1'b0;
		while (items_sent - start < budget) begin
			if (with_hold && !hold_asked && items_sent - start >= budget / 2) begin
				hold_asked = 1'b1;
				hold_requests++;
			end
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				send_random_frame();
			end else if (pick < 90) begin
				n = $urandom_range(1, 8);
				repeat (n) send_byte(8'($urandom), $urandom_range(0, 2) == 0);
			end else begin
				// A frame cut short; the next frame may or may not restart it.
				send_byte(8'($urandom), 1'b1);
				n = $urandom_range(0, 4);
				repeat (n) send_byte(8'($urandom), 1'b0);
			end
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_family(input logic [1:0] fam);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= fam;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.family = fam;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 14;
		recv_idle_pct = 82;
		write_family(FAM_ONE_BYTE);
		// Two bytes dropped by a restart, then scale extremes, then each word's CRC failing.
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b0);
		send_word_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		send_word_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
		send_word_frame(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b1);
		send_word_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1);
		run_random(100, 1'b0);
		wait_idle();

		write_family(FAM_PACKED);
		send_packed_frame(8'h00, 20'h80000, 20'h80000, 1'b1);
		send_packed_frame(8'h18, 20'hFFFFF, 20'h80000, 1'b1);
		run_random(100, 1'b0);
		wait_idle();

		send_idle_pct = 82;
		recv_idle_pct = 14;
		write_family(FAM_TWO_BYTE);
		send_word_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		run_random(100, 1'b0);
		wait_idle();

		write_family(FAM_SPARE);
		run_random(100, 1'b0);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_family(FAM_PACKED);
		run_random(110, 1'b1);
		wait_idle();

		write_family(FAM_ONE_BYTE);
		run_random(110, 1'b0);
		wait_idle();

		write_family(FAM_TWO_BYTE);
		run_random(110, 1'b0);
		wait_idle();

		if (sb.mismatches == 0 && sb.pending_readings.size() == 0)
			$display("humidity_sensor_frame_decoder_top_tb OK");
		else
			$display("humidity_sensor_frame_decoder_top_tb NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("humidity_sensor_frame_decoder_top_tb NOT OK");
		$finish;
	end

endmodule
